// ----- src/iirbq_pkg.sv -----
// shared constants, codes and the saturation helper for the biquad cascade core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iirbq_pkg;

  localparam int MAX_BIQUADS_DEF   = 8;
  localparam int WORDS_PER_BIQUAD  = 7;
  localparam int DELAYS_PER_BIQUAD = 2;
  localparam int Q30_SHIFT         = 30;
  localparam int GAIN_BASE_SHIFT   = 14;

  localparam logic signed [63:0] ROUND_Q30 = 64'sd1 <<< 29;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_BIQUAD_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SERIES_LENGTH = 1'b1;

  // request opcodes
  localparam logic OP_FILTER     = 1'b0;
  localparam logic OP_COEF_WRITE = 1'b1;

  // word offsets inside one biquad's coefficient block
  localparam logic [2:0] W_A2    = 3'd0;
  localparam logic [2:0] W_A1    = 3'd1;
  localparam logic [2:0] W_B2    = 3'd2;
  localparam logic [2:0] W_B1    = 3'd3;
  localparam logic [2:0] W_B0    = 3'd4;
  localparam logic [2:0] W_SHIFT = 3'd5;
  localparam logic [2:0] W_GAIN  = 3'd6;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/iirbq_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iirbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 56
) (
  input  wire logic                     clk,
  input  wire logic                     wen,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/iir_biquad_df2t_cascade_core.sv -----
// biquad cascade core: sequencer, shared 32x32 multiplier, coefficient and delay rams
// depends on iirbq_pkg and iirbq_ram
// a filter request returns the sum of B whole branches (S biquads per branch); with a zero
//   biquad count it passes the sample through; a coefficient write gives no result
// each biquad steps through its phases on the single multiplier fed from the coefficient ram
// one request at a time: ready again once the result sits in the output register
// reset clears control, count and delay valid bits, sets series length 1; coefs undefined
`timescale 1ns / 1ps
`default_nettype none

module iir_biquad_df2t_cascade_core #(
  parameter int MAX_BIQUADS = iirbq_pkg::MAX_BIQUADS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [iirbq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [iirbq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  opcode,
  input  wire logic signed [31:0]                    sample_in,
  input  wire logic [5:0]                            coef_index,
  input  wire logic signed [31:0]                    coef_value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [31:0]                         sample_out
);

  localparam int CDEPTH = iirbq_pkg::WORDS_PER_BIQUAD * MAX_BIQUADS;
  localparam int DDEPTH = iirbq_pkg::DELAYS_PER_BIQUAD * MAX_BIQUADS;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int DAW    = $clog2(DDEPTH);
  localparam int KW     = $clog2(MAX_BIQUADS + 1);

  // biquad phases
  localparam logic [3:0] PH_RD    = 4'd0;
  localparam logic [3:0] PH_B0X   = 4'd1;
  localparam logic [3:0] PH_B1X   = 4'd2;
  localparam logic [3:0] PH_Y     = 4'd3;
  localparam logic [3:0] PH_A1Y   = 4'd4;
  localparam logic [3:0] PH_A2Y   = 4'd5;
  localparam logic [3:0] PH_GAIN  = 4'd6;
  localparam logic [3:0] PH_ROUND = 4'd7;
  localparam logic [3:0] PH_OUT   = 4'd8;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_BIQ   = 5'b00100,
    ST_ACCUM = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [3:0] phase;
  logic [KW-1:0] k, kbase;
  logic [iirbq_pkg::CFG_DATA_W-1:0] biquad_count, series_length;
  logic [DDEPTH-1:0] dly_valid;

  logic signed [31:0] xin, xv, yv;
  logic signed [63:0] acc, accb, d1reg, prod, sum;
  logic dly_rd_valid;
  logic g_zero, g_none;
  logic [5:0] g_sh;

  logic [KW-1:0] cnt, ser;
  logic [KW:0] kbase_end, k_inc;
  logic branch_fits, last_in_branch;
  logic in_acc, load_out;

  logic [2:0] coef_word;
  logic coef_wen;
  logic [CAW-1:0] coef_waddr, coef_raddr;
  logic signed [31:0] coef_rdata;

  logic dly_wen;
  logic [DAW-1:0] dly_waddr, dly_raddr;
  logic [63:0] dly_wdata, dly_rdata;
  logic signed [63:0] dly_q;

  logic signed [31:0] mul_b, y_next, gain_out;
  logic signed [32:0] shift_sum;
  logic g_zero_next, g_none_next;
  logic signed [63:0] g_round;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign load_out  = !out_valid || out_ready;

  // clamp the configuration to the supported range
  always_comb begin
    if (int'(biquad_count) > MAX_BIQUADS) begin
      cnt = KW'(MAX_BIQUADS);
    end else begin
      cnt = KW'(biquad_count);
    end
    if (series_length == '0) begin
      ser = KW'(1);
    end else if (int'(series_length) > MAX_BIQUADS) begin
      ser = KW'(MAX_BIQUADS);
    end else begin
      ser = KW'(series_length);
    end
  end

  // a branch only runs when all of its biquads fit under the count
  assign kbase_end      = (KW+1)'(kbase) + (KW+1)'(ser);
  assign branch_fits    = kbase_end <= (KW+1)'(cnt);
  assign k_inc          = (KW+1)'(k) + (KW+1)'(1);
  assign last_in_branch = (k_inc == kbase_end);

  // coefficient fetch order, one word ahead of the multiplier
  always_comb begin
    case (phase)
      PH_RD:   coef_word = iirbq_pkg::W_B0;
      PH_B0X:  coef_word = iirbq_pkg::W_B1;
      PH_B1X:  coef_word = iirbq_pkg::W_B2;
      PH_Y:    coef_word = iirbq_pkg::W_A1;
      PH_A1Y:  coef_word = iirbq_pkg::W_A2;
      PH_A2Y:  coef_word = iirbq_pkg::W_GAIN;
      default: coef_word = iirbq_pkg::W_SHIFT;
    endcase
  end

  assign coef_raddr = CAW'(k) * CAW'(iirbq_pkg::WORDS_PER_BIQUAD) + CAW'(coef_word);
  assign coef_wen   = in_acc && (opcode == iirbq_pkg::OP_COEF_WRITE) && (int'(coef_index) < CDEPTH);
  assign coef_waddr = CAW'(coef_index);

  iirbq_ram #(
    .WIDTH(32),
    .DEPTH(CDEPTH)
  ) u_coef_ram (
    .clk  (clk),
    .wen  (coef_wen),
    .waddr(coef_waddr),
    .wdata(coef_value),
    .raddr(coef_raddr),
    .rdata(coef_rdata)
  );

  assign dly_raddr = DAW'({k, (phase == PH_B0X)});
  assign dly_wen   = (state == ST_BIQ) && (phase == PH_GAIN || phase == PH_ROUND);
  assign dly_waddr = DAW'({k, (phase == PH_ROUND)});
  assign dly_wdata = (phase == PH_ROUND) ? accb : acc;
  // an entry never written since reset reads as zero
  assign dly_q     = dly_rd_valid ? $signed(dly_rdata) : '0;

  iirbq_ram #(
    .WIDTH(64),
    .DEPTH(DDEPTH)
  ) u_dly_ram (
    .clk  (clk),
    .wen  (dly_wen),
    .waddr(dly_waddr),
    .wdata(dly_wdata),
    .raddr(dly_raddr),
    .rdata(dly_rdata)
  );

  assign mul_b  = (phase <= PH_Y) ? xv : yv;
  assign y_next = iirbq_pkg::sat32(acc >>> iirbq_pkg::Q30_SHIFT);

  // gain stage setup from the shift word
  assign shift_sum   = $signed({coef_rdata[31], coef_rdata})
                       + 33'(iirbq_pkg::GAIN_BASE_SHIFT);
  assign g_zero_next = shift_sum >= 33'sd63;
  assign g_none_next = shift_sum <= 33'sd0;
  assign g_round     = (!g_zero_next && !g_none_next)
                       ? (64'sd1 <<< (shift_sum[5:0] - 6'd1)) : '0;

  always_comb begin
    if (g_zero) begin
      gain_out = '0;
    end else if (g_none) begin
      gain_out = iirbq_pkg::sat32(acc);
    end else begin
      gain_out = iirbq_pkg::sat32(acc >>> g_sh);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && opcode == iirbq_pkg::OP_FILTER) begin
          state_next = (cnt == '0) ? ST_DONE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = branch_fits ? ST_BIQ : ST_DONE;
      end
      ST_BIQ: begin
        if (phase == PH_OUT && last_in_branch) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_RD;
      k             <= '0;
      kbase         <= '0;
      out_valid     <= 1'b0;
      biquad_count  <= '0;
      series_length <= iirbq_pkg::CFG_DATA_W'(1);
      dly_valid     <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          iirbq_pkg::REG_BIQUAD_COUNT:  biquad_count  <= cfg_data;
          iirbq_pkg::REG_SERIES_LENGTH: series_length <= cfg_data;
          default: ;
        endcase
      end
      if (dly_wen) begin
        dly_valid[dly_waddr] <= 1'b1;
      end
      if (in_acc) begin
        kbase <= '0;
      end
      if (state == ST_CHECK && branch_fits) begin
        k     <= kbase;
        phase <= PH_RD;
      end
      if (state == ST_BIQ) begin
        if (phase == PH_OUT) begin
          if (!last_in_branch) begin
            k     <= KW'(k_inc);
            phase <= PH_RD;
          end
        end else begin
          phase <= phase + 4'd1;
        end
      end
      if (state == ST_ACCUM) begin
        kbase <= KW'(k_inc);
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_DONE && load_out) begin
        out_valid <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod         <= coef_rdata * mul_b;
    dly_rd_valid <= dly_valid[dly_raddr];
    if (in_acc) begin
      xin <= sample_in;
      sum <= (cnt == '0) ? 64'(sample_in) : '0;
    end
    if (state == ST_CHECK) begin
      xv <= xin;
    end
    if (state == ST_ACCUM) begin
      sum <= sum + 64'(xv);
    end
    if (state == ST_BIQ) begin
      case (phase)
        PH_B0X: acc <= dly_q;
        PH_B1X: begin
          acc   <= acc + prod + iirbq_pkg::ROUND_Q30;
          d1reg <= dly_q;
        end
        PH_Y: begin
          yv  <= y_next;
          acc <= d1reg + prod;
        end
        PH_A1Y: accb <= prod;
        PH_A2Y: acc  <= acc + prod;
        PH_GAIN: accb <= accb + prod;
        PH_ROUND: begin
          acc    <= prod + g_round;
          g_zero <= g_zero_next;
          g_none <= g_none_next;
          g_sh   <= shift_sum[5:0];
        end
        PH_OUT: xv <= gain_out;
        default: ;
      endcase
    end
    if (state == ST_DONE && load_out) begin
      sample_out <= iirbq_pkg::sat32(sum);
    end
  end

  // coefficient ram is only written between requests
  a_coef_write_idle: assert property (@(posedge clk) disable iff (rst)
    coef_wen |-> state == ST_IDLE)
    else $error("coefficient write while filtering");

  // the sequencer never runs past the clamped biquad count
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BIQ |-> k < cnt)
    else $error("biquad index beyond count");

  // after the last phase either the next biquad starts or the branch is summed
  a_phase_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BIQ && phase == PH_OUT) |=>
      ((state == ST_BIQ && phase == PH_RD) || state == ST_ACCUM))
    else $error("bad sequence after last biquad phase");

  // reset leaves every delay reading as zero
  a_dly_cleared: assert property (@(posedge clk)
    $past(rst) |-> dly_valid == '0)
    else $error("delay valid bits not cleared by reset");

endmodule

`default_nettype wire

// ----- dv/iir_biquad_df2t_cascade_core_tb.sv -----
// self-checking testbench for the biquad cascade core: directed and random requests
// depends on iirbq_pkg and iir_biquad_df2t_cascade_core
`timescale 1ns / 1ps

module iir_biquad_df2t_cascade_core_tb;

  localparam int NUM_BQ         = iirbq_pkg::MAX_BIQUADS_DEF;
  localparam int NUM_WORDS      = NUM_BQ * iirbq_pkg::WORDS_PER_BIQUAD;
  localparam int HOLD_OFF       = 100;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 160;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [iirbq_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [iirbq_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                              in_valid;
  logic                              in_ready;
  logic                              opcode;
  logic signed [31:0]                sample_in;
  logic [5:0]                        coef_index;
  logic signed [31:0]                coef_value;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [31:0]                sample_out;

  // filter state as the core should hold it
  longint          delay_mem [2*NUM_BQ];
  int              coef_mem  [NUM_WORDS];
  logic [3:0]      cfg_count;
  logic [3:0]      cfg_series;
  int              pending_outputs[$];

  int              error_count;
  int              idle_cycles;
  int              head_sample;
  bit              no_idle;

  iir_biquad_df2t_cascade_core #(
    .MAX_BIQUADS(NUM_BQ)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .sample_in(sample_in),
    .coef_index(coef_index),
    .coef_value(coef_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int gain_step(input int gain, input int y, input int shift);
    longint prod;
    longint s;
    prod = longint'(gain) * longint'(y);
    s = iirbq_pkg::GAIN_BASE_SHIFT + longint'(shift);
    if (s <= 0) return clip32(prod);
    if (s >= 63) return 0;
    return clip32((prod + (longint'(1) << (s - 1))) >>> s);
  endfunction

  function automatic int biquad_step(input int k, input int x);
    int     base;
    int     y;
    longint acc;
    base = k * iirbq_pkg::WORDS_PER_BIQUAD;
    acc = delay_mem[2*k] + longint'(coef_mem[base + iirbq_pkg::W_B0]) * longint'(x)
          + iirbq_pkg::ROUND_Q30;
    y = clip32(acc >>> iirbq_pkg::Q30_SHIFT);
    // delay sums wrap at 64 bits
    delay_mem[2*k] = delay_mem[2*k+1]
                     + longint'(coef_mem[base + iirbq_pkg::W_B1]) * longint'(x)
                     + longint'(coef_mem[base + iirbq_pkg::W_A1]) * longint'(y);
    delay_mem[2*k+1] = longint'(coef_mem[base + iirbq_pkg::W_B2]) * longint'(x)
                       + longint'(coef_mem[base + iirbq_pkg::W_A2]) * longint'(y);
    return gain_step(coef_mem[base + iirbq_pkg::W_GAIN], y,
                     coef_mem[base + iirbq_pkg::W_SHIFT]);
  endfunction

  // update the filter state for one accepted request and queue its output, if any
  function automatic void apply_request(input bit op, input int sample, input logic [5:0] idx,
                                        input int value);
    int     count;
    int     series;
    int     branches;
    int     v;
    longint total;
    if (op == iirbq_pkg::OP_COEF_WRITE) begin
      if (idx < NUM_WORDS) coef_mem[idx] = value;
      return;
    end
    count = (cfg_count > NUM_BQ) ? NUM_BQ : int'(cfg_count);
    if (count == 0) begin
      pending_outputs.push_back(sample);
      return;
    end
    series = (cfg_series == 0) ? 1 : ((cfg_series > NUM_BQ) ? NUM_BQ : int'(cfg_series));
    // partial branches are dropped
    branches = count / series;
    total = 0;
    for (int b = 0; b < branches; b++) begin
      v = sample;
      for (int i = 0; i < series; i++) v = biquad_step(b * series + i, v);
      total += v;
    end
    pending_outputs.push_back(clip32(total));
  endfunction

  // stable-ish coefficient words so that deep cascades still carry signal
  function automatic int gentle_word(input int w);
    int g;
    case (w)
      iirbq_pkg::W_A2:    return int'($urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
      iirbq_pkg::W_A1:    return int'($urandom_range(0, 32'h4000_0000) - 32'h2000_0000);
      iirbq_pkg::W_SHIFT: return int'($urandom_range(0, 3)) - 1;
      iirbq_pkg::W_GAIN: begin
        g = int'($urandom_range(4096, 32768));
        return ($urandom_range(0, 1) == 1) ? -g : g;
      end
      default: return int'($urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
    endcase
  endfunction

  function automatic int wild_word(input int w);
    if (w == iirbq_pkg::W_SHIFT) begin
      case ($urandom_range(0, 6))
        0: return -100;
        1: return -14;
        2: return -20;
        3: return 48;
        4: return 49;
        5: return 1000;
        default: return int'($urandom);
      endcase
    end
    case ($urandom_range(0, 3))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: return int'($urandom) >>> $urandom_range(0, 16);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("sample_out: expected none, actual %0d", sample_out);
        error_count++;
      end else begin
        head_sample = pending_outputs.pop_front();
        if (sample_out !== head_sample) begin
          $error("sample_out: expected %0d, actual %0d", head_sample, sample_out);
          error_count++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("iir_biquad_df2t_cascade_core_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input bit op, input int sample, input logic [5:0] idx,
                              input int value);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    opcode     <= op;
    sample_in  <= sample;
    coef_index <= idx;
    coef_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    apply_request(op, sample, idx, value);
  endtask

  task automatic send_sample(input int x);
    send_request(iirbq_pkg::OP_FILTER, x, 6'($urandom_range(0, 63)), int'($urandom));
  endtask

  task automatic write_coef(input int idx, input int value);
    send_request(iirbq_pkg::OP_COEF_WRITE, int'($urandom), 6'(idx), value);
  endtask

  task automatic drop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_results();
    drop_input();
    while (pending_outputs.size() != 0) @(posedge clk);
  endtask

  // coefficient writes give no result, so allow the longest filter latency on top
  task automatic wait_quiet();
    wait_results();
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_register(input logic [iirbq_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [3:0] data);
    wait_quiet();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == iirbq_pkg::REG_BIQUAD_COUNT) cfg_count = data;
    else cfg_series = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_unity_coefs();
    for (int k = 0; k < NUM_BQ; k++) begin
      for (int w = 0; w < iirbq_pkg::WORDS_PER_BIQUAD; w++) begin
        case (w)
          iirbq_pkg::W_B0:
            write_coef(k * iirbq_pkg::WORDS_PER_BIQUAD + w, 32'h4000_0000);
          iirbq_pkg::W_GAIN:
            write_coef(k * iirbq_pkg::WORDS_PER_BIQUAD + w, 16384);
          default:
            write_coef(k * iirbq_pkg::WORDS_PER_BIQUAD + w, 0);
        endcase
      end
    end
  endtask

  task automatic load_gentle_coefs();
    for (int i = 0; i < NUM_WORDS; i++) begin
      write_coef(i, gentle_word(i % iirbq_pkg::WORDS_PER_BIQUAD));
    end
  endtask

  // count is zero after reset, so samples pass straight through
  task automatic test_passthrough();
    send_sample(0);
    send_sample(32'h7fffffff);
    send_sample(32'h80000000);
    send_sample(-1);
    send_sample(1);
    // addresses past the coefficient store are ignored
    write_coef(NUM_WORDS, 32'h7fffffff);
    write_coef(63, 32'h80000000);
    send_sample(32'h5555_5555);
  endtask

  task automatic test_directed_filter();
    write_register(iirbq_pkg::REG_BIQUAD_COUNT, 4'd8);
    write_register(iirbq_pkg::REG_SERIES_LENGTH, 4'd1);
    send_sample(32'h7fffffff);
    send_sample(32'h80000000);
    send_sample(1);
    send_sample(-1);
    write_register(iirbq_pkg::REG_SERIES_LENGTH, 4'd8);
    send_sample(32'h1234_5678);
    // fewer biquads than one branch needs
    write_register(iirbq_pkg::REG_BIQUAD_COUNT, 4'd3);
    write_register(iirbq_pkg::REG_SERIES_LENGTH, 4'd5);
    send_sample(1000);
    // out of range settings are clamped
    write_register(iirbq_pkg::REG_BIQUAD_COUNT, 4'd15);
    write_register(iirbq_pkg::REG_SERIES_LENGTH, 4'd0);
    send_sample(-12345);
    write_register(iirbq_pkg::REG_SERIES_LENGTH, 4'd15);
    send_sample(32'h4000_0000);
    write_register(iirbq_pkg::REG_BIQUAD_COUNT, 4'd1);
    write_register(iirbq_pkg::REG_SERIES_LENGTH, 4'd1);
    // gain stage with no shift at all
    write_coef(iirbq_pkg::W_GAIN, 1);
    write_coef(iirbq_pkg::W_SHIFT, -14);
    send_sample(32'h00ab_cdef);
    write_coef(iirbq_pkg::W_SHIFT, -20);
    send_sample(32'h7fffffff);
    // widest shift that still rounds, then one that clears the output
    write_coef(iirbq_pkg::W_GAIN, 32'h7fffffff);
    write_coef(iirbq_pkg::W_SHIFT, 48);
    send_sample(32'h80000000);
    write_coef(iirbq_pkg::W_SHIFT, 49);
    send_sample(32'h7fffffff);
    // extreme feedback, delays wrap
    write_coef(iirbq_pkg::W_A1, 32'h7fffffff);
    write_coef(iirbq_pkg::W_A2, 32'h80000000);
    write_coef(iirbq_pkg::W_B0, 32'h80000000);
    write_coef(iirbq_pkg::W_SHIFT, 0);
    write_coef(iirbq_pkg::W_GAIN, 16384);
    send_sample(32'h7fffffff);
    send_sample(32'h80000000);
    send_sample(32'h7fffffff);
  endtask

  task automatic test_random_phases();
    logic [3:0] count;
    logic [3:0] series;
    int         r;
    int         idx;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin count = 4'd8; series = 4'd1; end
        1: begin count = 4'd8; series = 4'd8; end
        2: begin count = 4'd4; series = 4'd2; end
        3: begin count = 4'd15; series = 4'd0; end
        4: begin count = 4'd0; series = 4'd1; end
        5: begin count = 4'd6; series = 4'd3; end
        6: begin count = 4'd3; series = 4'd5; end
        7: begin count = 4'd8; series = 4'd4; end
        8: begin count = 4'($urandom); series = 4'($urandom); end
        default: begin count = 4'd8; series = 4'd2; end
      endcase
      write_register(iirbq_pkg::REG_BIQUAD_COUNT, count);
      write_register(iirbq_pkg::REG_SERIES_LENGTH, series);
      if (p == PHASES - 1) no_idle = 1'b1;
      if (p == 0 || $urandom_range(0, 2) == 0) load_gentle_coefs();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // let the core run dry once per phase
        if (n == PHASE_ITEMS / 2) wait_results();
        r = $urandom_range(0, 99);
        if (r < 10) begin
          idx = $urandom_range(0, NUM_WORDS - 1);
          write_coef(idx, gentle_word(idx % iirbq_pkg::WORDS_PER_BIQUAD));
        end else if (r < 14) begin
          idx = $urandom_range(0, 63);
          write_coef(idx, wild_word(idx % iirbq_pkg::WORDS_PER_BIQUAD));
        end else begin
          send_sample(pick_sample());
        end
      end
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    opcode      = iirbq_pkg::OP_FILTER;
    sample_in   = '0;
    coef_index  = '0;
    coef_value  = '0;
    error_count = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    cfg_count   = 4'd0;
    cfg_series  = 4'd1;
    foreach (delay_mem[i]) delay_mem[i] = 0;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_passthrough();
    load_unity_coefs();
    test_directed_filter();
    test_random_phases();
    wait_quiet();

    if (error_count == 0) begin
      $display("iir_biquad_df2t_cascade_core_tb: clean");
    end else begin
      $display("iir_biquad_df2t_cascade_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/iirbq_pkg.sv
src/iirbq_ram.sv
src/iir_biquad_df2t_cascade_core.sv
dv/iir_biquad_df2t_cascade_core_tb.sv
